@@ hdl/scu_pkg.sv @@
// Package with the shared constants and the term pipeline bus of the sine/cosine unit.
package scu_pkg;

  localparam logic [37:0] HALF_PI_Q32       = 38'h01921FB544;
  localparam logic [37:0] PI_Q32            = 38'h03243F6A89;
  localparam logic [37:0] THREE_HALF_PI_Q32 = 38'h04B65F1FCD;
  localparam logic [37:0] TWO_PI_Q32        = 38'h06487ED511;
  localparam logic [33:0] ONE_Q30           = 34'h040000000;

  typedef struct packed {
    logic               valid;
    logic               neg;
    logic [31:0]        x2;
    logic [30:0]        term;
    logic signed [33:0] sum;
  } term_bus_t;

endpackage

@@ hdl/scu_term.sv @@
// One Taylor term stage: multiplies by x squared and divides by a constant.
module scu_term #(
  parameter int K = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scu_pkg::term_bus_t bus_i,
  output scu_pkg::term_bus_t bus_o
);
  import scu_pkg::*;

  localparam int          C     = (2 * K) * (2 * K + 1);
  localparam logic [63:0] RECIP = (64'd1 << 33) / C;
  localparam logic [63:0] RND   = 64'(C) << 29;

  term_bus_t   a_r, b_r, c_r;
  logic [62:0] prod_r;
  logic [32:0] y_r;
  logic [63:0] qm_r;

  logic [63:0] y_full;
  logic [32:0] y_nxt;
  logic [63:0] qm_nxt;
  logic [30:0] q0;
  logic [41:0] rem;
  logic [30:0] q;
  term_bus_t   c_nxt;

  always_comb begin
    y_full = {1'b0, prod_r} + RND;
    y_nxt  = y_full[62:30];
    qm_nxt = 64'(y_nxt) * RECIP[30:0];
    q0     = qm_r[63:33];
    rem    = 42'(y_r) - 42'(q0) * 42'(C);
    q      = (rem >= 42'(C)) ? q0 + 31'd1 : q0;
    c_nxt      = b_r;
    c_nxt.term = q;
    if (K % 2 == 1) begin
      c_nxt.sum = b_r.sum - 34'(q);
    end else begin
      c_nxt.sum = b_r.sum + 34'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
    end else begin
      a_r <= bus_i;
      b_r <= a_r;
      c_r <= c_nxt;
    end
    prod_r <= 63'(bus_i.term) * 63'(bus_i.x2);
    y_r    <= y_nxt;
    qm_r   <= qm_nxt;
  end

  assign bus_o = c_r;

endmodule

@@ hdl/sine_cosine_unit.sv @@
// Top level of the pipelined fixed-point sine/cosine unit.
// Takes one item per clock cycle and never asserts busy; each result appears on
// out_value with out_valid high for one cycle, after the angle reduction stages,
// three stages per Taylor term and the output register.
// The receiver cannot stall the block, so it must take each result in the cycle it appears.
module sine_cosine_unit #(
  parameter int NUM_TERMS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  output logic signed [31:0] out_value
);
  import scu_pkg::*;

  logic               v_t_r, v_m_r, v_a_r, v_b_r, v_c_r, v_x_r, v_s_r;
  logic signed [38:0] t_r;
  logic [37:0]        m_r, ma_r, mb_r, mc_r;
  logic               n_m_r, n_a_r, n_b_r, n_c_r, n_x_r, n_s_r;
  logic [30:0]        x_r, xs_r;
  logic [61:0]        sq_r;
  logic               out_valid_r;
  logic signed [31:0] out_value_r;
  term_bus_t          bus0_r;

  logic signed [38:0] a_ext;
  logic signed [38:0] t_nxt;
  logic [37:0]        fold_m;
  logic               fold_n;
  logic [37:0]        x_wide;
  logic [62:0]        sq_rnd;
  logic [30:0]        mag;
  term_bus_t          bus0_nxt;

  term_bus_t bus [NUM_TERMS];

  assign busy = 1'b0;

  always_comb begin
    a_ext = 39'({{7{in_angle[31]}}, in_angle} <<< 6);
    t_nxt = in_mode ? ($signed({1'b0, HALF_PI_Q32}) - a_ext) : a_ext;
    fold_n = n_c_r;
    fold_m = mc_r;
    if (mc_r > THREE_HALF_PI_Q32) begin
      fold_n = !n_c_r;
      fold_m = TWO_PI_Q32 - mc_r;
    end else if (mc_r > PI_Q32) begin
      fold_n = !n_c_r;
      fold_m = mc_r - PI_Q32;
    end else if (mc_r > HALF_PI_Q32) begin
      fold_m = PI_Q32 - mc_r;
    end
    x_wide = (fold_m + 38'd2) >> 2;
    sq_rnd = {1'b0, sq_r} + (63'd1 << 29);
    bus0_nxt.valid = v_s_r;
    bus0_nxt.neg   = n_s_r;
    bus0_nxt.x2    = sq_rnd[61:30];
    bus0_nxt.term  = xs_r;
    bus0_nxt.sum   = $signed({3'b000, xs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_t_r <= 1'b0;
      v_m_r <= 1'b0;
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_x_r <= 1'b0;
      v_s_r <= 1'b0;
    end else begin
      v_t_r <= start;
      v_m_r <= v_t_r;
      v_a_r <= v_m_r;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_x_r <= v_c_r;
      v_s_r <= v_x_r;
    end
    t_r   <= t_nxt;
    n_m_r <= t_r[38];
    m_r   <= t_r[38] ? 38'(-t_r) : t_r[37:0];
    n_a_r <= n_m_r;
    ma_r  <= (m_r >= (TWO_PI_Q32 << 2)) ? m_r - (TWO_PI_Q32 << 2) : m_r;
    n_b_r <= n_a_r;
    mb_r  <= (ma_r >= (TWO_PI_Q32 << 1)) ? ma_r - (TWO_PI_Q32 << 1) : ma_r;
    n_c_r <= n_b_r;
    mc_r  <= (mb_r >= TWO_PI_Q32) ? mb_r - TWO_PI_Q32 : mb_r;
    n_x_r <= fold_n;
    x_r   <= x_wide[30:0];
    n_s_r <= n_x_r;
    xs_r  <= x_r;
    sq_r  <= 62'(x_r) * 62'(x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus0_r <= '0;
    end else begin
      bus0_r <= bus0_nxt;
    end
  end

  assign bus[0] = bus0_r;

  for (genvar k = 1; k < NUM_TERMS; k++) begin : g_term
    scu_term #(.K(k)) u_term (
      .clk  (clk),
      .rst_n(rst_n),
      .bus_i(bus[k-1]),
      .bus_o(bus[k])
    );
  end

  always_comb begin
    if (bus[NUM_TERMS-1].sum < 0) begin
      mag = 31'd0;
    end else if (bus[NUM_TERMS-1].sum > $signed(ONE_Q30)) begin
      mag = ONE_Q30[30:0];
    end else begin
      mag = bus[NUM_TERMS-1].sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= bus[NUM_TERMS-1].valid;
    end
    out_value_r <= bus[NUM_TERMS-1].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

`ifndef NO_ASSERTIONS
  a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_c_r |-> mc_r < TWO_PI_Q32) else $error("reduced angle not below two pi");
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_x_r |-> x_r <= 31'(HALF_PI_Q32 >> 2) + 31'd1) else $error("folded angle too large");
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value <= 32'sh40000000 && out_value >= -32'sh40000000))
    else $error("result outside plus or minus one");
  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
`endif

endmodule

@@ dv/sine_cosine_checker.sv @@
// Checker that predicts each sine or cosine result and compares it with the block's output.
module sine_cosine_checker #(
  parameter int NUM_TERMS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_mode,
  input  logic signed [31:0] in_angle,
  input  logic               out_valid,
  input  logic signed [31:0] out_value,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import scu_pkg::*;

  logic [31:0] expected_values[$];

  function automatic logic [31:0] predict_value(logic mode, logic signed [31:0] angle);
    logic signed [63:0] a;
    logic signed [63:0] t;
    logic [63:0] m;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] den;
    logic signed [63:0] sum;
    logic neg;
    a = 64'(angle) <<< 6;
    t = mode ? $signed(64'(HALF_PI_Q32)) - a : a;
    neg = t < 0;
    m = neg ? -t : t;
    m = m % 64'(TWO_PI_Q32);
    if (m > 64'(THREE_HALF_PI_Q32)) begin
      neg = !neg;
      m = 64'(TWO_PI_Q32) - m;
    end else if (m > 64'(PI_Q32)) begin
      neg = !neg;
      m = m - 64'(PI_Q32);
    end else if (m > 64'(HALF_PI_Q32)) begin
      m = 64'(PI_Q32) - m;
    end
    x = (m + 2) >> 2;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = $signed(x);
    for (int k = 1; k < NUM_TERMS; k++) begin
      den = 64'((2 * k) * (2 * k + 1)) << 30;
      term = (term * x2 + den / 2) / den;
      if (k % 2 == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    if (sum > $signed(64'(ONE_Q30))) sum = $signed(64'(ONE_Q30));
    return neg ? 32'(-sum) : 32'(sum);
  endfunction

  assign pending = expected_values.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        if (expected_values.size() == 0) begin
          $error("out_value: no item pending, actual %0d", out_value);
          fail_count <= fail_count + 1;
        end else if (expected_values[0] !== out_value) begin
          $error("out_value: expected %0d actual %0d", $signed(expected_values[0]), out_value);
          fail_count <= fail_count + 1;
          void'(expected_values.pop_front());
        end else begin
          void'(expected_values.pop_front());
        end
      end
      if (start && !busy) expected_values.push_back(predict_value(in_mode, in_angle));
    end
  end
endmodule

@@ dv/tb_sine_cosine_unit.sv @@
// Testbench top that drives angle items into the sine/cosine unit and reports the verdict.
module tb_sine_cosine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 6 + 3 * (8 - 1) + 2;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic in_mode;
  logic signed [31:0] in_angle;
  logic out_valid;
  logic signed [31:0] out_value;
  int fail_count;
  int pending;
  int cycle_count;

  sine_cosine_unit dut (.*);

  sine_cosine_checker checker_inst (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic send_item(logic mode, logic [31:0] angle);
    start <= 1'b1;
    in_mode <= mode;
    in_angle <= angle;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0800_0000) ^ {32{$urandom_range(0, 1) == 1}};
      2: return 32'h0648_7ED5 * $urandom_range(0, 20) + $urandom_range(0, 8) - 4;
      default: return 32'h0192_1FB5 * ($urandom_range(0, 40) - 20) + $urandom_range(0, 6) - 3;
    endcase
  endfunction

  initial begin
    logic [31:0] corner_angles[12] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
      32'h8000_0000, 32'h0648_7ED5, 32'h0324_3F6A, 32'h0192_1FB5, 32'h04B6_5F1F,
      32'hFE6D_E04B, 32'hAAAA_AAAA, 32'h5555_5555};
    int wait_count;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= 1'b0;
    in_angle <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner_angles[i]) begin
      send_item(1'b0, corner_angles[i]);
      send_item(1'b1, corner_angles[i]);
    end
    for (int n = 0; n < 800; n++) send_item($urandom_range(0, 1), random_angle());
    start <= 1'b0;
    wait_count = 0;
    while (pending != 0 && wait_count < 10 * LATENCY) begin
      @(posedge clk);
      wait_count++;
    end
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
